@@ design/wfp_pkg.sv @@
`default_nettype none
package wfp_pkg;

    // Parse phases of the frame header and payload
    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5
    } t_phase;

    // Opcodes defined by the framing protocol
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    // Header byte fields
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Configuration register map (byte address = 4 * index)
    localparam int         ADDR_W          = 3;
    localparam logic [0:0] REG_TEXT_ONLY   = 1'b0;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_frame;
        logic       empty_frame;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic [1:0] frame_status;
    } t_result;

    function automatic logic [1:0] status_of(input logic [3:0] op, input logic text_only);
        logic [1:0] st;
        if (text_only) begin
            st = (op == OP_TEXT) ? ST_OK : ST_REJECTED;
        end else begin
            case (op)
                OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: st = ST_OK;
                default: st = ST_UNKNOWN;
            endcase
        end
        return st;
    endfunction

endpackage
`default_nettype wire

@@ design/websocket_frame_parser_unit.sv @@
`default_nettype none
// Path: an input transfer is held in the input register; its result is then held in
//   the result register on the master side. Throughput: one byte per cycle while the
//   master side accepts results, with the header/payload update between the registers.
// Reset: synchronous, active low; parser returns to the first header byte,
//   both pipeline registers empty, text-only mode cleared.
module websocket_frame_parser_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Input stream
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [7:0]                 i_s_axis_tdata,   // [7:0] stream_byte
    // Result stream
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic      [7:0]                 o_m_axis_tdata,   // [7:0] payload_byte
    output logic                            o_m_axis_tlast,   // last_of_frame
    output logic      [7:0]                 o_m_axis_tuser,   // [0] empty_frame,
                                                              // [4:1] frame_opcode,
                                                              // [5] final_fragment,
                                                              // [7:6] frame_status
    // Configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [wfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    import wfp_pkg::*;

    logic       text_only;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       advance;
    logic       step;
    logic       res_valid;
    t_result    res;

    wfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_text_only (text_only)
    );

    // Result register is free when empty or being drained this cycle
    assign advance = !r_out_valid || i_m_axis_tready;
    // Parser consumes the held byte only when its result has somewhere to go
    assign step    = r_in_valid && advance;
    // Input register takes a new byte when empty or handing its byte on
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Payload register: no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    wfp_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_text_only (text_only),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Header bytes leave a bubble; payload bytes and empty frames load a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.payload_byte;
    assign o_m_axis_tlast  = r_out.last_of_frame;
    assign o_m_axis_tuser  = {r_out.frame_status, r_out.final_fragment,
                              r_out.frame_opcode, r_out.empty_frame};

endmodule
`default_nettype wire

@@ design/wfp_cfg_regs.sv @@
`default_nettype none
module wfp_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [wfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic                            o_text_only
);
    import wfp_pkg::*;

    logic r_text_only;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_TEXT_ONLY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_only <= 1'b0;
        end else if (wr_en) begin
            r_text_only <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[ADDR_W-1] == REG_TEXT_ONLY) begin
            prdata[0] = r_text_only;
        end
    end

    assign o_text_only = r_text_only;

endmodule
`default_nettype wire

@@ design/wfp_deframer.sv @@
`default_nettype none
module wfp_deframer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_text_only,
    output logic                  o_res_valid,
    output wfp_pkg::t_result      o_res
);
    import wfp_pkg::*;

    t_phase      r_phase,     n_phase;
    logic [3:0]  r_opcode,    n_opcode;
    logic        r_fin,       n_fin;
    logic        r_masked,    n_masked;
    logic [63:0] r_len,       n_len;
    logic [2:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [31:0] r_key,       n_key;
    logic [1:0]  r_mask_pos,  n_mask_pos;
    logic [63:0] r_remaining, n_remaining;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_opcode    <= 4'd0;
            r_fin       <= 1'b0;
            r_masked    <= 1'b0;
            r_len       <= 64'd0;
            r_hdr_cnt   <= 3'd0;
            r_key       <= 32'd0;
            r_mask_pos  <= 2'd0;
            r_remaining <= 64'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_fin       <= n_fin;
            r_masked    <= n_masked;
            r_len       <= n_len;
            r_hdr_cnt   <= n_hdr_cnt;
            r_key       <= n_key;
            r_mask_pos  <= n_mask_pos;
            r_remaining <= n_remaining;
        end
    end

    always_comb begin
        logic        len_done;
        logic [7:0]  key_byte;
        logic [63:0] rem_dec;
        len_done    = 1'b0;
        key_byte    = 8'd0;
        rem_dec     = r_remaining - 64'd1;

        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_fin       = r_fin;
        n_masked    = r_masked;
        n_len       = r_len;
        n_hdr_cnt   = r_hdr_cnt;
        n_key       = r_key;
        n_mask_pos  = r_mask_pos;
        n_remaining = r_remaining;

        o_res_valid          = 1'b0;
        o_res.payload_byte   = 8'd0;
        o_res.last_of_frame  = 1'b0;
        o_res.empty_frame    = 1'b0;
        o_res.frame_opcode   = r_opcode;
        o_res.final_fragment = r_fin;
        o_res.frame_status   = status_of(r_opcode, i_text_only);

        case (r_phase)
            PH_HDR1: begin
                n_masked  = i_byte[7];
                n_hdr_cnt = 3'd0;
                n_len     = 64'd0;
                if (i_byte[6:0] == LEN_EXT16) begin
                    n_phase = PH_EXT16;
                end else if (i_byte[6:0] == LEN_EXT64) begin
                    n_phase = PH_EXT64;
                end else begin
                    n_len    = {57'd0, i_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64: begin
                n_len = {r_len[55:0], i_byte};
                if (r_hdr_cnt >= ((r_phase == PH_EXT16) ? 3'd1 : 3'd7)) begin
                    len_done = 1'b1;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], i_byte};
                if (r_hdr_cnt >= 3'd3) begin
                    // Key complete: start payload or emit the empty-frame result
                    n_mask_pos = 2'd0;
                    n_hdr_cnt  = 3'd0;
                    if (r_len == 64'd0) begin
                        n_phase             = PH_HDR0;
                        n_remaining         = 64'd0;
                        o_res_valid         = 1'b1;
                        o_res.last_of_frame = 1'b1;
                        o_res.empty_frame   = 1'b1;
                    end else begin
                        n_remaining = r_len;
                        n_phase     = PH_DATA;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end
            end
            PH_DATA: begin
                if (r_masked) begin
                    case (r_mask_pos)
                        2'd0:    key_byte = r_key[31:24];
                        2'd1:    key_byte = r_key[23:16];
                        2'd2:    key_byte = r_key[15:8];
                        default: key_byte = r_key[7:0];
                    endcase
                end
                n_mask_pos          = r_mask_pos + 2'd1;
                n_remaining         = rem_dec;
                o_res_valid         = 1'b1;
                o_res.payload_byte  = i_byte ^ key_byte;
                o_res.last_of_frame = (rem_dec == 64'd0);
                if (rem_dec == 64'd0) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_fin      = i_byte[7];
                n_opcode   = i_byte[3:0];
                n_masked   = 1'b0;
                n_len      = 64'd0;
                n_hdr_cnt  = 3'd0;
                n_mask_pos = 2'd0;
                n_phase    = PH_HDR1;
            end
        endcase

        // Length known: fetch the key when masked, else start the payload or emit the empty-frame result
        if (len_done) begin
            n_hdr_cnt = 3'd0;
            if (n_masked) begin
                n_key   = 32'd0;
                n_phase = PH_MASK;
            end else begin
                n_mask_pos = 2'd0;
                if (n_len == 64'd0) begin
                    n_phase             = PH_HDR0;
                    n_remaining         = 64'd0;
                    o_res_valid         = 1'b1;
                    o_res.last_of_frame = 1'b1;
                    o_res.empty_frame   = 1'b1;
                end else begin
                    n_remaining = n_len;
                    n_phase     = PH_DATA;
                end
            end
        end
    end

endmodule
`default_nettype wire
